### sv/wpp_pkg.sv
// shared constants, types and helpers for the window peak-to-peak noise detector
// no dependencies; used by wpp_cfg_regs, the core and the testbench
`default_nettype none

package wpp_pkg;

    // field widths
    localparam int SAMPLE_W   = 24;
    localparam int THR_W      = 24;
    localparam int CFG_LEN_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int SPREAD_W   = SAMPLE_W + 2;

    // window store geometry
    localparam int WINDOW_MAX = 16;
    localparam int ADDR_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_NAT_W  = $clog2(WINDOW_MAX + 1);
    localparam int LEN_W      = (LEN_NAT_W > CFG_LEN_W) ? LEN_NAT_W : CFG_LEN_W;

    localparam logic [LEN_W-1:0] LEN_ONE = LEN_W'(1);
    localparam logic [LEN_W-1:0] LEN_TWO = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WINDOW_MAX);

    // cap of the running minimum and floor of the running maximum
    localparam logic signed [SAMPLE_W-1:0] EXTREME_HI = SAMPLE_W'(5000000);
    localparam logic signed [SAMPLE_W-1:0] EXTREME_LO = SAMPLE_W'(-5000000);

    // register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW_LENGTH = CFG_IDX_W'(1);
    localparam logic [THR_W-1:0]     THRESHOLD_RESET       = THR_W'(0);
    localparam logic [CFG_LEN_W-1:0] WINDOW_LENGTH_RESET   = CFG_LEN_W'(5);

    typedef struct packed {
        logic [THR_W-1:0]     threshold;
        logic [CFG_LEN_W-1:0] window_length;
    } cfg_t;

    // window length saturated to the store depth
    function automatic logic [LEN_W-1:0] sat_len(input logic [CFG_LEN_W-1:0] wl);
        logic [LEN_W-1:0] wl_ext;
        wl_ext = LEN_W'(wl);
        if (wl_ext > LEN_MAX)
            return LEN_MAX;
        return wl_ext;
    endfunction

endpackage

`default_nettype wire

### sv/wpp_ram.sv
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module wpp_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### sv/wpp_cfg_regs.sv
// configuration registers: threshold and window length
// depends on wpp_pkg
`default_nettype none

module wpp_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wpp_pkg::CFG_DATA_W-1:0] cfg_data,
    output wpp_pkg::cfg_t                       cfg
);

    wpp_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold     <= wpp_pkg::THRESHOLD_RESET;
            cfg_reg.window_length <= wpp_pkg::WINDOW_LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == wpp_pkg::CFG_IDX_THRESHOLD)
                cfg_reg.threshold <= cfg_data[wpp_pkg::THR_W-1:0];
            else if (cfg_index == wpp_pkg::CFG_IDX_WINDOW_LENGTH)
                cfg_reg.window_length <= cfg_data[wpp_pkg::CFG_LEN_W-1:0];
        end
    end

endmodule

`default_nettype wire

### sv/window_peak_to_peak_noise_detect_core.sv
// window peak-to-peak noise detector, top level with the window sequencer
// each input transaction walks the window (saturated length, 0..16) through S_SCAN, S_CMP and S_OUT;
//   zero length skips the walk and goes straight to S_OUT
// one transaction at a time: in_ready only in S_IDLE, after the result is registered; one window entry per cycle
// reset: async active low; control and config registers to reset values, window reads zero via entry valid flops
// depends on wpp_pkg, wpp_ram, wpp_cfg_regs
`default_nettype none

module window_peak_to_peak_noise_detect_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [wpp_pkg::SAMPLE_W-1:0] sample,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                noise_flag,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [wpp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [wpp_pkg::CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_CMP  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    wpp_pkg::cfg_t cfg;

    logic [wpp_pkg::LEN_W-1:0]            len_sat;
    logic [wpp_pkg::LEN_W-1:0]            len_last;
    logic [wpp_pkg::LEN_W-1:0]            cnt_reg;
    logic [wpp_pkg::LEN_W-1:0]            rd_idx;
    logic [wpp_pkg::ADDR_W-1:0]           rd_addr;
    logic                                 rd_hit_reg;
    logic                                 rd_hit_next;
    logic [wpp_pkg::SAMPLE_W-1:0]         rd_data;
    logic [wpp_pkg::WINDOW_MAX-1:0]       valid_reg;
    logic signed [wpp_pkg::SAMPLE_W-1:0]  sample_reg;
    logic signed [wpp_pkg::SAMPLE_W-1:0]  hi_reg;
    logic signed [wpp_pkg::SAMPLE_W-1:0]  lo_reg;
    logic signed [wpp_pkg::SAMPLE_W-1:0]  scan_val;
    logic signed [wpp_pkg::SPREAD_W-1:0]  spread;
    logic signed [wpp_pkg::SPREAD_W-1:0]  thr_ext;
    logic                                 flag_reg;
    logic                                 out_valid_reg;
    logic                                 noise_reg;
    logic                                 accept;
    logic                                 scan_last;
    logic                                 out_free;
    logic                                 wr_en;

    wpp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // handshake and walk control
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign len_sat   = wpp_pkg::sat_len(cfg.window_length);
    assign len_last  = len_sat - wpp_pkg::LEN_ONE;
    assign scan_last = (cnt_reg == len_last);
    assign out_free  = !out_valid_reg || out_ready;
    assign wr_en     = (state_reg == S_SCAN);

    // read one entry ahead of the write position
    assign rd_idx      = accept ? wpp_pkg::LEN_ONE : (cnt_reg + wpp_pkg::LEN_TWO);
    assign rd_addr     = rd_idx[wpp_pkg::ADDR_W-1:0];
    assign rd_hit_next = (rd_idx < wpp_pkg::LEN_MAX) && valid_reg[rd_addr];

    wpp_ram #(
        .WIDTH (wpp_pkg::SAMPLE_W),
        .DEPTH (wpp_pkg::WINDOW_MAX)
    ) u_window (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[wpp_pkg::ADDR_W-1:0]),
        .wr_data (scan_val),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // shifted value for this position: next entry, or the new sample at the top
    always_comb
    begin
        if (scan_last)
            scan_val = sample_reg;
        else if (rd_hit_reg)
            scan_val = $signed(rd_data);
        else
            scan_val = '0;
    end

    // spread of the window against the threshold
    assign spread  = {{2{hi_reg[wpp_pkg::SAMPLE_W-1]}}, hi_reg}
                   - {{2{lo_reg[wpp_pkg::SAMPLE_W-1]}}, lo_reg};
    assign thr_ext = $signed({2'b00, cfg.threshold});

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (len_sat == '0) ? S_OUT : S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_last)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            rd_hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_hit_reg <= rd_hit_next;
            if (accept)
                cnt_reg <= '0;
            else if (state_reg == S_SCAN)
                cnt_reg <= cnt_reg + wpp_pkg::LEN_ONE;
            if (wr_en)
                valid_reg[cnt_reg[wpp_pkg::ADDR_W-1:0]] <= 1'b1;
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers: sample, running extremes, flag and output
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            hi_reg     <= wpp_pkg::EXTREME_LO;
            lo_reg     <= wpp_pkg::EXTREME_HI;
            flag_reg   <= 1'b1;
        end
        else if (state_reg == S_SCAN)
        begin
            if (scan_val > hi_reg)
                hi_reg <= scan_val;
            if (scan_val < lo_reg)
                lo_reg <= scan_val;
        end
        else if (state_reg == S_CMP)
        begin
            flag_reg <= (spread > thr_ext);
        end
        if (state_reg == S_OUT && out_free)
            noise_reg <= flag_reg;
    end

    assign out_valid  = out_valid_reg;
    assign noise_flag = noise_reg;

endmodule

`default_nettype wire

### tb/tb.sv
// self-checking testbench for the window peak-to-peak noise detector core
// depends on wpp_pkg and window_peak_to_peak_noise_detect_core; keeps its own window
// predictor and compares every output transaction against it
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_ITEMS = 30;

    // indexes past the register list, writes there must be dropped
    localparam logic [wpp_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = wpp_pkg::CFG_IDX_W'(2);
    localparam logic [wpp_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = wpp_pkg::CFG_IDX_W'(3);

    // stimulus flavors for the random phases
    typedef enum int {
        MODE_FULL,
        MODE_NARROW,
        MODE_NEAR_LIMIT
    } sample_mode_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic signed [wpp_pkg::SAMPLE_W-1:0]  sample_d = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic                                 noise_flag;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [wpp_pkg::CFG_IDX_W-1:0]        cfg_index = '0;
    logic [wpp_pkg::CFG_DATA_W-1:0]       cfg_data = '0;

    // predictor state, window zeroed as after reset
    logic [wpp_pkg::THR_W-1:0]            spread_limit = wpp_pkg::THRESHOLD_RESET;
    logic [wpp_pkg::CFG_LEN_W-1:0]        span_len = wpp_pkg::WINDOW_LENGTH_RESET;
    logic signed [wpp_pkg::SAMPLE_W-1:0]  recent_samples [wpp_pkg::WINDOW_MAX] = '{default: '0};

    logic                                 noise_expect_q [$];
    logic                                 want_flag;
    int                                   mismatch_count = 0;
    int                                   idle_cycles = 0;
    bit                                   calm = 1'b0;

    window_peak_to_peak_noise_detect_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample     (sample_d),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .noise_flag (noise_flag),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shift the new sample into the window and decide the flag
    function automatic logic predict_noise(input logic signed [wpp_pkg::SAMPLE_W-1:0] s);
        int n;
        int i;
        int hi;
        int lo;
        int v;
        int spread;
        n = (span_len > wpp_pkg::WINDOW_MAX) ? wpp_pkg::WINDOW_MAX : int'(span_len);
        if (n == 0)
            return 1'b1;
        for (i = 1; i < n; i++)
            recent_samples[i-1] = recent_samples[i];
        recent_samples[n-1] = s;
        hi = int'(wpp_pkg::EXTREME_LO);
        lo = int'(wpp_pkg::EXTREME_HI);
        for (i = 0; i < n; i++)
        begin
            v = int'(recent_samples[i]);
            if (v > hi)
                hi = v;
            if (v < lo)
                lo = v;
        end
        spread = hi - lo;
        if (spread < 0)
            spread = -spread;
        return spread > int'({8'd0, spread_limit});
    endfunction

    task automatic report_mismatch(input string what, input logic want, input logic got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("noise_flag mismatch (%s): expected %b, got %b at %0t",
                     what, want, got, $realtime);
    endtask

    // receiver stalls
    always @(posedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 13);

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (noise_expect_q.size() == 0)
                report_mismatch("no transaction pending", 1'bx, noise_flag);
            else
            begin
                want_flag = noise_expect_q.pop_front();
                if (noise_flag !== want_flag)
                    report_mismatch("wrong value", want_flag, noise_flag);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // one input transaction; valid is left high for a back-to-back follower
    task automatic send_sample(input logic signed [wpp_pkg::SAMPLE_W-1:0] s);
        if (!calm)
            while ($urandom_range(0, 99) < 13)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid <= 1'b1;
        sample_d <= s;
        do
            @(posedge clk);
        while (!in_ready);
        noise_expect_q.push_back(predict_noise(s));
    endtask

    // stop sending and wait for every pending result
    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (noise_expect_q.size() != 0)
            @(posedge clk);
    endtask

    // one register transaction; caller lowers cfg_valid after the last one
    task automatic write_reg(input logic [wpp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wpp_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            wpp_pkg::CFG_IDX_THRESHOLD:     spread_limit = data[wpp_pkg::THR_W-1:0];
            wpp_pkg::CFG_IDX_WINDOW_LENGTH: span_len = data[wpp_pkg::CFG_LEN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [wpp_pkg::THR_W-1:0] thr,
                             input logic [wpp_pkg::CFG_DATA_W-1:0] len_word);
        drain();
        write_reg(wpp_pkg::CFG_IDX_THRESHOLD, thr);
        write_reg(wpp_pkg::CFG_IDX_WINDOW_LENGTH, len_word);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [wpp_pkg::SAMPLE_W-1:0] rand_sample(
        input sample_mode_t mode, input int base);
        int v;
        case (mode)
            MODE_NARROW:
                v = base + $urandom_range(0, 2000) - 1000;
            MODE_NEAR_LIMIT:
            begin
                v = 5000000 + $urandom_range(0, 3388607) - $urandom_range(0, 1500000);
                if ($urandom_range(0, 1) == 1)
                    v = -v - 1;
            end
            default:
                v = int'($urandom);
        endcase
        return wpp_pkg::SAMPLE_W'(v);
    endfunction

    // reset values: threshold zero, length five, zeroed window
    task automatic test_reset_window;
        send_sample(24'sd0);
        send_sample(24'sd0);
        send_sample(24'sd1);
    endtask

    // spare indexes ignored, length taken from the low bits and saturated
    task automatic test_register_writes;
        drain();
        write_reg(CFG_IDX_SPARE_A, 24'hFFFFFF);
        write_reg(CFG_IDX_SPARE_B, 24'hABCDEF);
        write_reg(wpp_pkg::CFG_IDX_WINDOW_LENGTH, 24'hFFFFE3);
        write_reg(wpp_pkg::CFG_IDX_THRESHOLD, 24'd100);
        cfg_valid <= 1'b0;
        send_sample(24'sd50);
        send_sample(-24'sd50);
        send_sample(24'sd60);
        configure(24'd1000, 24'd31);
        send_sample(24'sd900);
        send_sample(-24'sd200);
    endtask

    // full-scale samples and windows beyond the floor and cap
    task automatic test_extremes;
        configure(24'hFFFFFF, 24'd4);
        send_sample(-24'sd8388608);
        send_sample(24'sd8388607);
        configure(24'd9999999, 24'd2);
        send_sample(-24'sd5000001);
        send_sample(24'sd5000001);
        configure(24'd0, 24'd2);
        send_sample(-24'sd8388608);
        send_sample(-24'sd6000000);
        configure(24'd1000000, 24'd2);
        send_sample(-24'sd5500000);
        send_sample(24'sd5500000);
        send_sample(24'sd6000000);
    endtask

    // zero length always flags and must not touch the store
    task automatic test_zero_length;
        configure(24'd0, 24'd3);
        send_sample(24'sd7);
        send_sample(24'sd7);
        send_sample(24'sd7);
        configure(24'd0, 24'd0);
        send_sample(-24'sd8388608);
        send_sample(24'sd8388607);
        send_sample(24'sd12345);
        configure(24'd0, 24'd3);
        send_sample(24'sd7);
    endtask

    // random settings and samples, two phases without any idling
    task automatic test_random;
        int phase;
        int k;
        int pick;
        int base;
        logic [wpp_pkg::CFG_LEN_W-1:0] len;
        logic [wpp_pkg::THR_W-1:0] thr;
        sample_mode_t mode;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: len = wpp_pkg::CFG_LEN_W'(0);
                1: len = wpp_pkg::CFG_LEN_W'(1);
                2: len = wpp_pkg::CFG_LEN_W'(wpp_pkg::WINDOW_MAX);
                3: len = wpp_pkg::CFG_LEN_W'($urandom_range(wpp_pkg::WINDOW_MAX + 1, 31));
                default: len = wpp_pkg::CFG_LEN_W'($urandom_range(2, wpp_pkg::WINDOW_MAX - 1));
            endcase
            mode = sample_mode_t'($urandom_range(0, 2));
            base = $urandom_range(0, 8000000) - 4000000;
            case (mode)
                MODE_NARROW:     thr = wpp_pkg::THR_W'($urandom_range(0, 2500));
                MODE_NEAR_LIMIT: thr = wpp_pkg::THR_W'($urandom_range(0, 6000000));
                default:         thr = wpp_pkg::THR_W'($urandom_range(0, 11000000));
            endcase
            if ($urandom_range(0, 3) == 0)
                thr = wpp_pkg::THR_W'($urandom);
            configure(thr, {(wpp_pkg::CFG_DATA_W - wpp_pkg::CFG_LEN_W)'($urandom), len});
            calm = (phase == 5) || (phase == 6);
            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                send_sample(rand_sample(mode, base));
                if (!calm && $urandom_range(0, 39) == 0)
                    drain();
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_window();
        test_register_writes();
        test_extremes();
        test_zero_length();
        test_random();
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && noise_expect_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
